FILE: src/reed_solomon_encoder_unit_defines.svh
// assertion macros for the reed-solomon encoder unit
// used by reed_solomon_encoder_unit.sv, expects clk and arst_n in scope
`ifndef REED_SOLOMON_ENCODER_UNIT_DEFINES_SVH
`define REED_SOLOMON_ENCODER_UNIT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define RSE_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define RSE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/rse_pkg.sv
// shared types, constants and gf(256) helpers for the reed-solomon encoder unit
// no dependencies
`default_nettype none

package rse_pkg;

	localparam int MAX_PARITY_DEF = 32;
	localparam int SYM_W          = 8;
	localparam int CNT_W          = 8;
	localparam int CNT_SUM_W      = 9;
	localparam int CODE_MAX       = 255;
	localparam int CFG_PC_W       = 6;
	localparam int CFG_FP_W       = 9;
	localparam int CFG_DATA_W     = 9;
	localparam int CFG_IDX_W      = 2;

	localparam logic [CFG_IDX_W-1:0] REG_PARITY_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FIELD_POLY   = 2'd1;

	localparam logic [CFG_PC_W-1:0] PARITY_COUNT_RST = 6'd10;
	localparam logic [CFG_FP_W-1:0] FIELD_POLY_RST   = 9'd285;

	typedef logic [SYM_W-1:0] sym_t;

	typedef struct packed {
		sym_t code_symbol;
		logic is_parity;
		logic code_last;
		logic too_long;
	} rse_res_t;

	// multiply by x, reduced by the low byte of the field polynomial
	function automatic sym_t gf_xtime(input sym_t a, input sym_t red);
		gf_xtime = a[SYM_W-1] ? ({a[SYM_W-2:0], 1'b0} ^ red) : {a[SYM_W-2:0], 1'b0};
	endfunction

	// shift-and-add gf(256) product
	function automatic sym_t gf_mul(input sym_t a, input sym_t b, input sym_t red);
		sym_t x;
		sym_t acc;
		x   = a;
		acc = '0;
		for (int k = 0; k < SYM_W; k++) begin
			if (b[k])
				acc = acc ^ x;
			x = gf_xtime(x, red);
		end
		gf_mul = acc;
	endfunction

endpackage

`default_nettype wire

FILE: src/reed_solomon_encoder_unit.sv
// systematic reed-solomon encoder over gf(256), generator built in place
// depends on rse_pkg and reed_solomon_encoder_unit_defines.svh
`default_nettype none

// Message bytes are taken one per cycle while in_ready is high and returned unchanged with
// is_parity low; the parity register is updated in the same cycle by one constant-depth gf
// multiply per tap. When the byte flagged msg_last is taken, the nsym parity bytes follow
// highest first, one per cycle while the queue has room, and the input is held until all
// are queued. A byte that would push the codeword past 255 bytes comes back with too_long
// set and is not absorbed. After reset and after every parity count or field polynomial
// write the generator polynomial is rebuilt, one root per cycle, with the input held
// meanwhile; such a write also drops any message in progress. Results pass through a
// two-entry output queue, so the input side never waits on out_ready in the same cycle.

module reed_solomon_encoder_unit #(
	parameter int MAX_PARITY = rse_pkg::MAX_PARITY_DEF
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         cfg_we,
	input  wire [rse_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire [rse_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire                         in_valid,
	output logic                        in_ready,
	input  wire [rse_pkg::SYM_W-1:0]    msg_symbol,
	input  wire                         msg_last,
	output logic                        out_valid,
	input  wire                         out_ready,
	output logic [rse_pkg::SYM_W-1:0]   code_symbol,
	output logic                        is_parity,
	output logic                        code_last,
	output logic                        too_long
);
	import rse_pkg::*;

	`include "reed_solomon_encoder_unit_defines.svh"

	localparam int NW = $clog2(MAX_PARITY + 1);

	logic [CFG_PC_W-1:0] pc_q;
	logic [CFG_FP_W-1:0] fp_q;
	sym_t                red;
	logic [NW-1:0]       nsym;

	logic                build_q;
	logic [NW-1:0]       bi_q;
	sym_t                root_q;
	sym_t                gen_q [MAX_PARITY];
	sym_t                gen_nxt [MAX_PARITY];

	sym_t                par_q [MAX_PARITY];
	sym_t                par_ext [MAX_PARITY+1];
	sym_t                par_nxt [MAX_PARITY];
	logic [CNT_W-1:0]    cnt_q;
	logic                reject;
	sym_t                fb;

	sym_t                drn_q [MAX_PARITY];
	sym_t                drn_ext [MAX_PARITY+1];
	logic [NW-1:0]       drn_cnt_q;

	rse_res_t            ent0_q;
	rse_res_t            ent1_q;
	logic [1:0]          fcnt_q;
	logic                push;
	logic                pop;
	rse_res_t            push_d;
	logic                in_acc;
	logic                drn_push;
	logic                cfg_hit;

	assign red = fp_q[SYM_W-1:0];

	always_comb begin
		if (int'(pc_q) > MAX_PARITY)
			nsym = NW'(MAX_PARITY);
		else
			nsym = NW'(pc_q);
	end

	// one generator root per cycle: g[k] ^= g[k-1] * root over all taps
	always_comb begin
		gen_nxt[0] = gen_q[0] ^ root_q;
		for (int k = 1; k < MAX_PARITY; k++)
			gen_nxt[k] = gen_q[k] ^ gf_mul(gen_q[k-1], root_q, red);
	end

	// parity register update, taps above nsym stay zero
	assign reject = ({1'b0, cnt_q} + CNT_SUM_W'(1) + CNT_SUM_W'(nsym)) > CNT_SUM_W'(CODE_MAX);
	assign fb     = msg_symbol ^ par_q[0];

	always_comb begin
		for (int j = 0; j < MAX_PARITY; j++) begin
			par_ext[j] = par_q[j];
			drn_ext[j] = drn_q[j];
		end
		par_ext[MAX_PARITY] = '0;
		drn_ext[MAX_PARITY] = '0;
		for (int j = 0; j < MAX_PARITY; j++) begin
			if (reject)
				par_nxt[j] = par_q[j];
			else
				par_nxt[j] = par_ext[j+1] ^ gf_mul(gen_q[j], fb, red);
		end
	end

	assign cfg_hit  = cfg_we && (cfg_index == REG_PARITY_COUNT || cfg_index == REG_FIELD_POLY);
	assign in_ready = !build_q && (drn_cnt_q == '0) && (fcnt_q != 2'd2);
	assign in_acc   = in_valid && in_ready;
	assign drn_push = (drn_cnt_q != '0) && (fcnt_q != 2'd2);
	assign push     = in_acc || drn_push;
	assign pop      = out_valid && out_ready;

	always_comb begin
		if (in_acc) begin
			push_d.code_symbol = msg_symbol;
			push_d.is_parity   = 1'b0;
			push_d.code_last   = msg_last && (nsym == '0);
			push_d.too_long    = reject;
		end else begin
			push_d.code_symbol = drn_q[0];
			push_d.is_parity   = 1'b1;
			push_d.code_last   = (drn_cnt_q == NW'(1));
			push_d.too_long    = 1'b0;
		end
	end

	// configuration and generator build
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q    <= PARITY_COUNT_RST;
			fp_q    <= FIELD_POLY_RST;
			build_q <= 1'b1;
			bi_q    <= '0;
			root_q  <= sym_t'(1);
			for (int k = 0; k < MAX_PARITY; k++)
				gen_q[k] <= '0;
		end else if (cfg_hit) begin
			if (cfg_index == REG_PARITY_COUNT)
				pc_q <= cfg_data[CFG_PC_W-1:0];
			else
				fp_q <= cfg_data[CFG_FP_W-1:0];
			build_q <= 1'b1;
			bi_q    <= '0;
			root_q  <= sym_t'(1);
			for (int k = 0; k < MAX_PARITY; k++)
				gen_q[k] <= '0;
		end else if (build_q) begin
			if (bi_q == nsym) begin
				build_q <= 1'b0;
			end else begin
				bi_q   <= bi_q + NW'(1);
				root_q <= gf_xtime(root_q, red);
				for (int k = 0; k < MAX_PARITY; k++)
					gen_q[k] <= gen_nxt[k];
			end
		end
	end

	// parity register, byte count and parity drain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			drn_cnt_q <= '0;
			for (int j = 0; j < MAX_PARITY; j++) begin
				par_q[j] <= '0;
				drn_q[j] <= '0;
			end
		end else if (cfg_hit) begin
			cnt_q <= '0;
			for (int j = 0; j < MAX_PARITY; j++)
				par_q[j] <= '0;
		end else if (in_acc) begin
			if (msg_last) begin
				cnt_q     <= '0;
				drn_cnt_q <= nsym;
				for (int j = 0; j < MAX_PARITY; j++) begin
					drn_q[j] <= par_nxt[j];
					par_q[j] <= '0;
				end
			end else begin
				if (!reject)
					cnt_q <= cnt_q + CNT_W'(1);
				for (int j = 0; j < MAX_PARITY; j++)
					par_q[j] <= par_nxt[j];
			end
		end else if (drn_push) begin
			drn_cnt_q <= drn_cnt_q - NW'(1);
			for (int j = 0; j < MAX_PARITY; j++)
				drn_q[j] <= drn_ext[j+1];
		end
	end

	// two-entry output queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fcnt_q <= '0;
			ent0_q <= '0;
			ent1_q <= '0;
		end else begin
			if (pop) begin
				if (fcnt_q == 2'd2) begin
					ent0_q <= ent1_q;
					if (push)
						ent1_q <= push_d;
				end else if (push) begin
					ent0_q <= push_d;
				end
			end else if (push) begin
				if (fcnt_q == 2'd0)
					ent0_q <= push_d;
				else
					ent1_q <= push_d;
			end
			fcnt_q <= fcnt_q + 2'(push) - 2'(pop);
		end
	end

	assign out_valid   = (fcnt_q != 2'd0);
	assign code_symbol = ent0_q.code_symbol;
	assign is_parity   = ent0_q.is_parity;
	assign code_last   = ent0_q.code_last;
	assign too_long    = ent0_q.too_long;

	`RSE_ASSERT_NOW(a_queue_bound, 1'b1, fcnt_q != 2'd3, "output queue overflow")
	`RSE_ASSERT_NEXT(a_drain_load, in_acc && msg_last && !cfg_hit, drn_cnt_q == $past(nsym),
		"parity drain not loaded with nsym bytes")
	`RSE_ASSERT_NOW(a_len_bound, !build_q,
		({1'b0, cnt_q} + CNT_SUM_W'(nsym)) <= CNT_SUM_W'(CODE_MAX), "codeword length exceeded")
	`RSE_ASSERT_NOW(a_drain_no_build, drn_cnt_q != '0, !build_q, "parity drain during build")

endmodule

`default_nettype wire

FILE: tb/tb_reed_solomon_encoder_unit.sv
// testbench for reed_solomon_encoder_unit: byte streams with random handshake gaps,
// each codeword byte checked against a parity predictor kept in a small scoreboard class
// depends on rse_pkg and reed_solomon_encoder_unit
import rse_pkg::*;

class rs_parity_scoreboard;
	logic [CFG_PC_W-1:0] parity_count;
	logic [CFG_FP_W-1:0] field_poly;
	sym_t remainder[MAX_PARITY_DEF];
	sym_t gen_taps[MAX_PARITY_DEF];
	int absorbed;
	rse_res_t codeword_q[$];
	int unsigned mismatches;

	function new();
		parity_count = PARITY_COUNT_RST;
		field_poly   = FIELD_POLY_RST;
		mismatches   = 0;
		rebuild_generator();
	endfunction

	function int active_nsym();
		return (parity_count > MAX_PARITY_DEF) ? MAX_PARITY_DEF : int'(parity_count);
	endfunction

	// bit 8 of the field polynomial is taken as set
	function sym_t gf_product(sym_t a, sym_t b);
		sym_t acc;
		sym_t x;
		acc = '0;
		x   = a;
		for (int k = 0; k < SYM_W; k++) begin
			if (b[k])
				acc ^= x;
			x = x[SYM_W-1] ? ({x[SYM_W-2:0], 1'b0} ^ field_poly[SYM_W-1:0])
				: {x[SYM_W-2:0], 1'b0};
		end
		return acc;
	endfunction

	// product of (x + 2^i), leading one dropped; also clears the message
	function void rebuild_generator();
		sym_t g[MAX_PARITY_DEF+1];
		sym_t root;
		int n;
		n = active_nsym();
		foreach (g[k])
			g[k] = '0;
		g[0] = 8'd1;
		root = 8'd1;
		for (int i = 0; i < n; i++) begin
			for (int k = i + 1; k >= 1; k--)
				g[k] ^= gf_product(g[k-1], root);
			root = gf_product(root, 8'd2);
		end
		foreach (gen_taps[i])
			gen_taps[i] = (i < n) ? g[i+1] : '0;
		foreach (remainder[i])
			remainder[i] = '0;
		absorbed = 0;
	endfunction

	function void config_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		case (idx)
			REG_PARITY_COUNT: parity_count = data[CFG_PC_W-1:0];
			REG_FIELD_POLY:   field_poly = data[CFG_FP_W-1:0];
			default: return;
		endcase
		rebuild_generator();
	endfunction

	// one accepted message byte: queue the echoed byte and any parity bytes it releases
	function void encode_byte(sym_t sym, logic last);
		int n;
		sym_t fb;
		logic reject;
		rse_res_t r;
		n = active_nsym();
		reject = (absorbed + 1 + n) > CODE_MAX;
		if (!reject) begin
			fb = sym ^ ((n > 0) ? remainder[0] : 8'd0);
			for (int j = 0; j + 1 < n; j++)
				remainder[j] = remainder[j+1] ^ gf_product(gen_taps[j], fb);
			if (n > 0)
				remainder[n-1] = gf_product(gen_taps[n-1], fb);
			absorbed++;
		end
		r.code_symbol = sym;
		r.is_parity   = 1'b0;
		r.code_last   = last && (n == 0);
		r.too_long    = reject;
		codeword_q.push_back(r);
		if (last) begin
			for (int j = 0; j < n; j++) begin
				r.code_symbol = remainder[j];
				r.is_parity   = 1'b1;
				r.code_last   = (j + 1 == n);
				r.too_long    = 1'b0;
				codeword_q.push_back(r);
			end
			foreach (remainder[i])
				remainder[i] = '0;
			absorbed = 0;
		end
	endfunction

	function int pending();
		return codeword_q.size();
	endfunction

	task report(string msg);
		$display("mismatch: %s", msg);
		mismatches++;
	endtask

	task check_code_byte(rse_res_t got);
		rse_res_t want;
		if (codeword_q.size() == 0) begin
			report($sformatf("unexpected byte %02h parity %b last %b too_long %b",
				got.code_symbol, got.is_parity, got.code_last, got.too_long));
			return;
		end
		want = codeword_q.pop_front();
		if (got.code_symbol !== want.code_symbol)
			report($sformatf("code_symbol %02h, want %02h", got.code_symbol, want.code_symbol));
		if (got.is_parity !== want.is_parity)
			report($sformatf("is_parity %b, want %b (byte %02h)", got.is_parity,
				want.is_parity, want.code_symbol));
		if (got.code_last !== want.code_last)
			report($sformatf("code_last %b, want %b (byte %02h)", got.code_last,
				want.code_last, want.code_symbol));
		if (got.too_long !== want.too_long)
			report($sformatf("too_long %b, want %b (byte %02h)", got.too_long,
				want.too_long, want.code_symbol));
	endtask
endclass

module tb_reed_solomon_encoder_unit;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
	localparam int MAX_GAP = 18;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [SYM_W-1:0] msg_symbol = '0;
	logic msg_last = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [SYM_W-1:0] code_symbol;
	logic is_parity;
	logic code_last;
	logic too_long;

	rs_parity_scoreboard sb = new();
	bit in_fast = 1'b0;
	bit out_fast = 1'b0;
	int unsigned long_hold_cycles = 0;

	reed_solomon_encoder_unit u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.msg_symbol  (msg_symbol),
		.msg_last    (msg_last),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.code_symbol (code_symbol),
		.is_parity   (is_parity),
		.code_last   (code_last),
		.too_long    (too_long)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("Verification failed");
		$finish;
	end

	// receiver
	initial begin
		int unsigned gap;
		rse_res_t got;
		wait (arst_n);
		@(negedge clk);
		forever begin
			if (long_hold_cycles > 0) begin
				out_ready <= 1'b0;
				repeat (long_hold_cycles) @(negedge clk);
				long_hold_cycles = 0;
			end
			gap = out_fast ? 0 : $urandom_range(0, MAX_GAP);
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!(out_valid && out_ready))
				@(posedge clk);
			got.code_symbol = code_symbol;
			got.is_parity   = is_parity;
			got.code_last   = code_last;
			got.too_long    = too_long;
			sb.check_code_byte(got);
			@(negedge clk);
		end
	end

	task automatic send_byte(input sym_t sym, input logic last);
		int unsigned gap;
		gap = in_fast ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid   <= 1'b1;
		msg_symbol <= sym;
		msg_last   <= last;
		@(posedge clk);
		while (!(in_valid && in_ready))
			@(posedge clk);
		sb.encode_byte(sym, last);
		@(negedge clk);
	endtask

	task automatic send_message(input int unsigned len, input bit ends);
		for (int unsigned i = 0; i < len; i++)
			send_byte(sym_t'($urandom_range(0, 255)), ends && (i == len - 1));
	endtask

	task automatic drain_codewords();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		while (!in_ready)
			@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		sb.config_write(idx, data);
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic random_phase(input int unsigned items);
		int unsigned sent;
		int unsigned len;
		logic [CFG_PC_W-1:0] pc;
		logic [CFG_FP_W-1:0] fp;
		case ($urandom_range(0, 9))
			0: pc = '0;
			1: pc = CFG_PC_W'($urandom_range(MAX_PARITY_DEF + 1, 63));
			2: pc = CFG_PC_W'(MAX_PARITY_DEF);
			3: pc = 6'd1;
			default: pc = CFG_PC_W'($urandom_range(1, MAX_PARITY_DEF));
		endcase
		fp = ($urandom_range(0, 7) == 0) ? CFG_FP_W'($urandom_range(0, 255))
			: CFG_FP_W'($urandom_range(256, 511));
		if ($urandom_range(0, 1)) begin
			write_reg(REG_PARITY_COUNT, CFG_DATA_W'(pc));
			write_reg(REG_FIELD_POLY, fp);
		end else begin
			write_reg(REG_FIELD_POLY, fp);
			write_reg(REG_PARITY_COUNT, CFG_DATA_W'(pc));
		end
		in_fast  = ($urandom_range(0, 3) == 0);
		out_fast = ($urandom_range(0, 3) == 0);
		sent = 0;
		while (sent < items) begin
			len = ($urandom_range(0, 4) == 0) ? 1 : $urandom_range(2, 12);
			// occasionally no end marker, so the message runs on or is dropped by a write
			send_message(len, $urandom_range(0, 9) != 0);
			sent += len;
		end
		drain_codewords();
	endtask

	initial begin
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		// reset configuration
		send_byte(8'h00, 1'b1);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'h01, 1'b0);
		send_byte(8'h7F, 1'b1);
		drain_codewords();

		write_reg(REG_PARITY_COUNT, 9'd1);
		write_reg(REG_FIELD_POLY, 9'd511);
		send_byte(8'hFF, 1'b1);
		send_byte(8'h55, 1'b0);
		send_byte(8'hAA, 1'b1);
		drain_codewords();

		// no parity bytes at all
		write_reg(REG_PARITY_COUNT, 9'd0);
		send_byte(8'h3C, 1'b1);
		send_byte(8'h01, 1'b0);
		send_byte(8'h02, 1'b1);
		drain_codewords();

		// saturating parity count, lowest field polynomial
		write_reg(REG_PARITY_COUNT, 9'd63);
		write_reg(REG_FIELD_POLY, 9'd256);
		send_byte(8'hC3, 1'b0);
		send_byte(8'h5A, 1'b1);
		drain_codewords();

		write_reg(REG_PARITY_COUNT, 9'd32);
		write_reg(REG_FIELD_POLY, 9'h11D);
		send_byte(8'h12, 1'b0);
		send_byte(8'h34, 1'b0);
		send_byte(8'h56, 1'b1);
		drain_codewords();

		// field polynomial without bit 8
		write_reg(REG_FIELD_POLY, 9'h02B);
		send_byte(8'h9A, 1'b0);
		send_byte(8'hBC, 1'b1);
		drain_codewords();

		// a write drops the message in progress
		write_reg(REG_PARITY_COUNT, 9'd5);
		send_byte(8'h11, 1'b0);
		send_byte(8'h22, 1'b0);
		send_byte(8'h33, 1'b0);
		drain_codewords();
		write_reg(REG_FIELD_POLY, 9'h11D);
		send_byte(8'h44, 1'b1);
		drain_codewords();

		// writes to unused indexes leave the message alone
		send_byte(8'h66, 1'b0);
		send_byte(8'h77, 1'b0);
		drain_codewords();
		write_reg(REG_SPARE_A, 9'h1FF);
		write_reg(REG_SPARE_B, 9'h000);
		send_byte(8'h88, 1'b1);
		drain_codewords();

		// overlong message with parity
		write_reg(REG_PARITY_COUNT, 9'd32);
		write_reg(REG_FIELD_POLY, 9'd285);
		in_fast  = 1'b1;
		out_fast = 1'b1;
		send_message(CODE_MAX - MAX_PARITY_DEF + 3, 1'b1);
		drain_codewords();
		in_fast  = 1'b0;
		out_fast = 1'b0;

		// receiver stalls long enough for the input to back up
		write_reg(REG_PARITY_COUNT, 9'd16);
		in_fast = 1'b1;
		long_hold_cycles = 150;
		send_message(10, 1'b1);
		send_message(10, 1'b1);
		drain_codewords();
		in_fast = 1'b0;

		repeat (3)
			random_phase(12);

		drain_codewords();
		repeat (40) @(negedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end
endmodule
